// File: hdl/swsc_pkg.sv
package swsc_pkg;

	typedef logic [2:0] seq_t;
	typedef logic [2:0] count_t;
	typedef logic [3:0] dup_t;

	typedef enum logic [1:0] {
		OP_SEND   = 2'd0,
		OP_ACK    = 2'd1,
		OP_EXPIRE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		TMR_NONE    = 2'd0,
		TMR_START   = 2'd1,
		TMR_RESTART = 2'd2
	} timer_act_t;

	typedef enum logic {
		REG_WINDOW_SIZE   = 1'b0,
		REG_DUP_THRESHOLD = 1'b1
	} reg_index_t;

	localparam int CFG_DATA_BITS = 4;

	localparam count_t WINDOW_SIZE_RESET   = 3'd3;
	localparam dup_t   DUP_THRESHOLD_RESET = 4'd3;
	localparam dup_t   DUP_MAX             = 4'd15;

endpackage

// File: hdl/swsc_req_if.sv
interface swsc_req_if #(
	parameter int PAYLOAD_BITS = 32
);
	import swsc_pkg::*;

	logic                    valid;
	logic                    ready;
	op_t                     operation;
	logic [PAYLOAD_BITS-1:0] payload;
	seq_t                    ack_num;
	logic                    ack_checksum_ok;
	seq_t                    expired_seq;

	modport source (
		output valid, operation, payload, ack_num, ack_checksum_ok, expired_seq,
		input  ready
	);

	modport sink (
		input  valid, operation, payload, ack_num, ack_checksum_ok, expired_seq,
		output ready
	);

endinterface

// File: hdl/swsc_rsp_if.sv
interface swsc_rsp_if #(
	parameter int PAYLOAD_BITS = 32
);
	import swsc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    send_accepted;
	logic                    tx_valid;
	seq_t                    tx_seq;
	logic [PAYLOAD_BITS-1:0] tx_payload;
	timer_act_t              timer_action;
	seq_t                    timer_seq;
	logic                    window_full;

	modport source (
		output valid, send_accepted, tx_valid, tx_seq, tx_payload, timer_action,
		       timer_seq, window_full,
		input  ready
	);

	modport sink (
		input  valid, send_accepted, tx_valid, tx_seq, tx_payload, timer_action,
		       timer_seq, window_full,
		output ready
	);

endinterface

// File: hdl/sliding_window_sender_control.sv
// go-back-n sender control with mod-8 sequence numbers and fast retransmit
//
// req carries one event per transfer: a send request with its payload, an
// arriving ack (number and checksum flag) or a timer expiry (its tag).
// rsp carries exactly one result per event: whether the send was taken, the
// packet to put on the network (new or resent), the timer command and tag,
// and whether the window is full afterwards.
// cfg_we/cfg_index/cfg_data write window_size (index 0) and dup_threshold
// (index 1); write them only while no event is in progress.
// a req transfer is taken into the input register; the logic behind it
// then writes the result register, where the window state and resend
// store update too. throughput: one event per cycle unless rsp stalls,
// set by the single state update stage.
// reset (arst_n low) empties the window, zeroes base and duplicate count and
// restores window_size 3, dup_threshold 3; the resend store is not cleared.
// when rsp stalls, the result is held and one more event can sit in the
// input register; req.ready then drops until rsp moves again.
module sliding_window_sender_control_core #(
	parameter int STORE_SLOTS  = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	swsc_req_if.sink                            req,
	swsc_rsp_if.source                          rsp,
	input  logic                                cfg_we,
	input  swsc_pkg::reg_index_t                cfg_index,
	input  logic [swsc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import swsc_pkg::*;

	localparam int SLOT_W = (STORE_SLOTS > 1) ? $clog2(STORE_SLOTS) : 1;
	localparam logic [3:0] SLOTS4 = 4'(STORE_SLOTS);

	// configuration
	count_t window_size_q;
	dup_t   dup_threshold_q;

	// window state
	seq_t              base_seq_q;
	count_t            in_flight_q;
	logic [SLOT_W-1:0] head_slot_q;
	dup_t              dup_count_q;
	logic              base_advanced_q;
	logic [PAYLOAD_BITS-1:0] store_q [STORE_SLOTS];

	// input stage
	logic                    valid_s1;
	op_t                     op_s1;
	logic [PAYLOAD_BITS-1:0] payload_s1;
	seq_t                    ack_s1;
	logic                    ck_ok_s1;
	seq_t                    exp_s1;

	// result register
	logic                    rsp_valid_q;
	logic                    accepted_q;
	logic                    txv_q;
	seq_t                    txs_q;
	logic [PAYLOAD_BITS-1:0] txp_q;
	timer_act_t              tact_q;
	seq_t                    tseq_q;
	logic                    full_q;

	logic advance;
	logic fire;

	count_t            eff_window;
	logic [3:0]        tail_sum;
	logic [SLOT_W-1:0] tail_slot;
	seq_t              ack_dist;
	count_t            free_cnt;
	logic [3:0]        head_sum;
	dup_t              dup_inc;

	seq_t              base_nxt;
	count_t            in_flight_nxt;
	logic [SLOT_W-1:0] head_nxt;
	dup_t              dup_nxt;
	logic              adv_nxt;
	logic              store_we;

	logic                    accepted_c;
	logic                    txv_c;
	seq_t                    txs_c;
	logic [PAYLOAD_BITS-1:0] txp_c;
	timer_act_t              tact_c;
	seq_t                    tseq_c;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	assign eff_window = (4'(window_size_q) < SLOTS4) ? window_size_q : 3'(STORE_SLOTS);

	// slot of the next free entry, wrapped by one compare and subtract
	assign tail_sum  = 4'(head_slot_q) + 4'(in_flight_q);
	assign tail_slot = (tail_sum >= SLOTS4) ? SLOT_W'(tail_sum - SLOTS4)
	                                        : SLOT_W'(tail_sum);

	assign ack_dist = ack_s1 - base_seq_q;
	assign free_cnt = ack_dist + 3'd1;
	assign head_sum = 4'(head_slot_q) + 4'(free_cnt);
	assign dup_inc  = (dup_count_q < DUP_MAX) ? dup_count_q + 4'd1 : dup_count_q;

	always_comb begin
		base_nxt      = base_seq_q;
		in_flight_nxt = in_flight_q;
		head_nxt      = head_slot_q;
		dup_nxt       = dup_count_q;
		adv_nxt       = base_advanced_q;
		store_we      = 1'b0;
		accepted_c    = 1'b0;
		txv_c         = 1'b0;
		txs_c         = '0;
		txp_c         = '0;
		tact_c        = TMR_NONE;
		tseq_c        = '0;
		case (op_s1)
			OP_SEND: begin
				if (in_flight_q < eff_window) begin
					store_we      = 1'b1;
					accepted_c    = 1'b1;
					txv_c         = 1'b1;
					txs_c         = base_seq_q + in_flight_q;
					txp_c         = payload_s1;
					if (in_flight_q == '0) begin
						tact_c = TMR_START;
						tseq_c = base_seq_q + in_flight_q;
					end
					in_flight_nxt = in_flight_q + 3'd1;
				end
			end
			OP_ACK: begin
				if (ck_ok_s1 && in_flight_q != '0) begin
					if (ack_dist < in_flight_q) begin
						// cumulative ack frees everything up to it
						base_nxt      = base_seq_q + free_cnt;
						head_nxt      = (head_sum >= SLOTS4) ? SLOT_W'(head_sum - SLOTS4)
						                                     : SLOT_W'(head_sum);
						in_flight_nxt = in_flight_q - free_cnt;
						dup_nxt       = '0;
						adv_nxt       = 1'b1;
						tact_c        = TMR_RESTART;
						tseq_c        = base_seq_q + free_cnt;
					end else if (base_advanced_q && ack_s1 == base_seq_q - 3'd1) begin
						dup_nxt = dup_inc;
						if (dup_inc >= dup_threshold_q) begin
							txv_c   = 1'b1;
							txs_c   = base_seq_q;
							txp_c   = store_q[head_slot_q];
							tact_c  = TMR_RESTART;
							tseq_c  = base_seq_q;
							dup_nxt = '0;
						end
					end
				end
			end
			OP_EXPIRE: begin
				if (in_flight_q != '0) begin
					txv_c  = 1'b1;
					txs_c  = base_seq_q;
					txp_c  = store_q[head_slot_q];
					tact_c = TMR_RESTART;
					tseq_c = exp_s1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= WINDOW_SIZE_RESET;
			dup_threshold_q <= DUP_THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_SIZE:   window_size_q   <= cfg_data[2:0];
				REG_DUP_THRESHOLD: dup_threshold_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1      <= req.operation;
			payload_s1 <= req.payload;
			ack_s1     <= req.ack_num;
			ck_ok_s1   <= req.ack_checksum_ok;
			exp_s1     <= req.expired_seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_seq_q      <= '0;
			in_flight_q     <= '0;
			head_slot_q     <= '0;
			dup_count_q     <= '0;
			base_advanced_q <= 1'b0;
		end else if (fire) begin
			base_seq_q      <= base_nxt;
			in_flight_q     <= in_flight_nxt;
			head_slot_q     <= head_nxt;
			dup_count_q     <= dup_nxt;
			base_advanced_q <= adv_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && store_we) begin
			store_q[tail_slot] <= payload_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_q <= accepted_c;
			txv_q      <= txv_c;
			txs_q      <= txs_c;
			txp_q      <= txp_c;
			tact_q     <= tact_c;
			tseq_q     <= tseq_c;
			full_q     <= (in_flight_nxt >= eff_window);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.send_accepted = accepted_q;
	assign rsp.tx_valid      = txv_q;
	assign rsp.tx_seq        = txs_q;
	assign rsp.tx_payload    = txp_q;
	assign rsp.timer_action  = tact_q;
	assign rsp.timer_seq     = tseq_q;
	assign rsp.window_full   = full_q;

endmodule
